FILE: hdl/inner_door_stepper_jam_recovery_unit_assert.svh
// Assertion helpers shared by the RTL; clocked on clk, quiet while rst is high.
`ifndef INNER_DOOR_STEPPER_JAM_RECOVERY_UNIT_ASSERT_SVH
`define INNER_DOOR_STEPPER_JAM_RECOVERY_UNIT_ASSERT_SVH

// same-cycle implication
`define IDSJ_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define IDSJ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: hdl/idsj_pkg.sv
`default_nettype none
package idsj_pkg;

  localparam int POSITION_BITS_DEF = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_OPEN_STEPS   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_STAGE_STEPS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_PAUSE_TICKS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JAM_PHASE_TICKS   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JAM_RETRY_MAX     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOICE_ALERT_MAX   = 3'd5;

  localparam logic [11:0] FULL_OPEN_STEPS_RST   = 12'd1000;
  localparam logic [11:0] FIRST_STAGE_STEPS_RST = 12'd500;
  localparam logic [9:0]  STAGE_PAUSE_TICKS_RST = 10'd667;
  localparam logic [7:0]  JAM_PHASE_TICKS_RST   = 8'd100;
  localparam logic [7:0]  JAM_RETRY_MAX_RST     = 8'd1;
  localparam logic [7:0]  VOICE_ALERT_MAX_RST   = 8'd2;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_OPEN        = 4'd1,
    PH_FEEDER_BACK = 4'd2,
    PH_FEEDER_WAIT = 4'd3,
    PH_CLOSE       = 4'd4,
    PH_CLOSE_CHECK = 4'd5,
    PH_DONE        = 4'd6,
    PH_ERROR       = 4'd7,
    PH_VOICE       = 4'd8
  } jam_phase_t;

  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2
  } outer_drive_t;

  typedef struct packed {
    logic open_set;
    logic open_clear;
    logic force_close_set;
    logic front_above_threshold;
    logic close_hold;
    logic extracting;
    logic reed_closed;
    logic jam_enable;
    logic outer_door_full;
    logic outer_door_shut;
    logic feeder_reverse_done;
    logic jam_check_set;
  } tick_t;

  typedef struct packed {
    logic [11:0] full_open_steps;
    logic [11:0] first_stage_steps;
    logic [9:0]  stage_pause_ticks;
    logic [7:0]  jam_phase_ticks;
    logic [7:0]  jam_retry_max;
    logic [7:0]  voice_alert_max;
  } cfg_t;

  typedef struct packed {
    logic opening;
    logic open_req;
    logic force_close;
  } door_flags_t;

  typedef struct packed {
    logic       pending;
    jam_phase_t phase;
    logic [7:0] timer;
    logic [7:0] retry;
    logic [7:0] voice_count;
    logic       feeder_busy;
  } jam_state_t;

  typedef struct packed {
    outer_drive_t drive;
    logic         feed;
    logic         voice;
  } jam_cmd_t;

  // half-step coil pattern, coil 1..4 on bits 0..3
  function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h9;
      3'd2: pat = 4'h8;
      3'd3: pat = 4'hC;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'h6;
      3'd6: pat = 4'h2;
      3'd7: pat = 4'h3;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/idsj_tick_if.sv
`default_nettype none
interface idsj_tick_if;
  logic valid;
  logic ready;
  logic open_set;
  logic open_clear;
  logic force_close_set;
  logic front_above_threshold;
  logic close_hold;
  logic extracting;
  logic reed_closed;
  logic jam_enable;
  logic outer_door_full;
  logic outer_door_shut;
  logic feeder_reverse_done;
  logic jam_check_set;

  modport source (
    output valid, open_set, open_clear, force_close_set, front_above_threshold,
           close_hold, extracting, reed_closed, jam_enable, outer_door_full,
           outer_door_shut, feeder_reverse_done, jam_check_set,
    input  ready
  );
  modport sink (
    input  valid, open_set, open_clear, force_close_set, front_above_threshold,
           close_hold, extracting, reed_closed, jam_enable, outer_door_full,
           outer_door_shut, feeder_reverse_done, jam_check_set,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/idsj_result_if.sv
`default_nettype none
interface idsj_result_if #(
  parameter int POSITION_BITS = idsj_pkg::POSITION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [3:0]               coil_phases;
  logic [POSITION_BITS-1:0] door_position;
  logic                     open_request;
  logic [1:0]               outer_door_drive;
  logic                     feeder_reverse_start;
  logic                     voice_alert;
  logic [3:0]               jam_phase;

  modport source (
    output valid, coil_phases, door_position, open_request, outer_door_drive,
           feeder_reverse_start, voice_alert, jam_phase,
    input  ready
  );
  modport sink (
    input  valid, coil_phases, door_position, open_request, outer_door_drive,
           feeder_reverse_start, voice_alert, jam_phase,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/idsj_cfg_if.sv
`default_nettype none
interface idsj_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [idsj_pkg::CFG_INDEX_BITS-1:0] index;
  logic [idsj_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/idsj_door.sv
`default_nettype none
module idsj_door #(
  parameter int POSITION_BITS = idsj_pkg::POSITION_BITS_DEF
) (
  input  idsj_pkg::tick_t           item,
  input  idsj_pkg::cfg_t            cfg,
  input  logic [POSITION_BITS-1:0]  position,
  input  idsj_pkg::door_flags_t     flags,
  input  logic [9:0]                pause_count,
  input  logic [3:0]                coil_reg,
  input  idsj_pkg::jam_phase_t      phase,
  output logic [POSITION_BITS-1:0]  position_next,
  output idsj_pkg::door_flags_t     flags_next,
  output logic [9:0]                pause_next,
  output logic [3:0]                coil_next,
  output logic                      run_jam
);
  import idsj_pkg::*;

  // wide enough for both the position and the 12-bit step registers
  localparam int W = (POSITION_BITS > 12) ? POSITION_BITS : 12;

  logic [W-1:0] pos_w, full_w, first_w, base_w, new_w;
  logic         req, fc, hold_coils;

  always_comb begin
    pos_w   = W'(position);
    full_w  = W'(cfg.full_open_steps);
    first_w = W'(cfg.first_stage_steps);
    base_w  = pos_w;
    req     = item.open_set ? 1'b1 : (item.open_clear ? 1'b0 : flags.open_req);
    fc      = flags.force_close | item.force_close_set;

    new_w      = pos_w;
    flags_next = '{opening: flags.opening, open_req: req, force_close: fc};
    pause_next = pause_count;
    run_jam    = 1'b1;
    hold_coils = 1'b0;

    if (fc) begin
      if (pos_w != '0) begin
        if (!item.close_hold) new_w = pos_w - W'(1);
      end else begin
        flags_next.force_close = 1'b0;
      end
      run_jam = 1'b0;
    end else if (req) begin
      flags_next.opening = 1'b1;
      if (item.front_above_threshold && pos_w < first_w) begin
        new_w      = pos_w + W'(1);
        pause_next = cfg.stage_pause_ticks;
      end else if (item.front_above_threshold && pos_w < full_w &&
                   pause_count != '0) begin
        // stage pause: hold coils, skip jam logic
        pause_next = pause_count - 10'd1;
        run_jam    = 1'b0;
        hold_coils = 1'b1;
      end else if (pos_w < full_w) begin
        new_w = pos_w + W'(1);
      end else begin
        new_w = full_w;
        if (!item.extracting && phase == PH_IDLE) flags_next.open_req = 1'b0;
      end
    end else begin
      if (flags.opening) base_w = full_w;
      flags_next.opening = 1'b0;
      new_w = (base_w != '0 && !item.close_hold) ? base_w - W'(1) : base_w;
    end

    if (hold_coils) begin
      coil_next = coil_reg;
    end else if (new_w == '0 || new_w == full_w) begin
      coil_next = 4'h0;
    end else begin
      coil_next = coil_pattern(new_w[2:0]);
    end

    position_next = new_w[POSITION_BITS-1:0];
  end

endmodule
`default_nettype wire

FILE: hdl/idsj_jam.sv
`default_nettype none
module idsj_jam #(
  parameter int POSITION_BITS = idsj_pkg::POSITION_BITS_DEF
) (
  input  idsj_pkg::tick_t          item,
  input  idsj_pkg::cfg_t           cfg,
  input  logic [POSITION_BITS-1:0] position,
  input  logic                     run_jam,
  input  logic                     open_req,
  input  idsj_pkg::jam_state_t     state,
  output idsj_pkg::jam_state_t     state_next,
  output logic                     open_req_next,
  output idsj_pkg::jam_cmd_t       cmd
);
  import idsj_pkg::*;

  localparam int W = (POSITION_BITS > 12) ? POSITION_BITS : 12;

  logic       pos_zero, at_full, retry_spent;
  logic [7:0] tick_count;
  jam_phase_t ph;

  always_comb begin
    pos_zero    = (position == '0);
    at_full     = (W'(position) == W'(cfg.full_open_steps));
    tick_count  = 8'd0;
    ph          = state.phase;
    retry_spent = 1'b0;

    state_next = state;
    state_next.pending     = state.pending | item.jam_check_set;
    state_next.feeder_busy = item.feeder_reverse_done ? 1'b0 : state.feeder_busy;
    open_req_next = open_req;
    cmd = '{drive: DRV_NONE, feed: 1'b0, voice: 1'b0};

    if (run_jam) begin
      if (!item.jam_enable || item.extracting) begin
        state_next.pending = 1'b0;
        state_next.phase   = PH_IDLE;
        state_next.timer   = 8'd0;
        state_next.retry   = 8'd0;
      end else begin
        tick_count = state.timer;
        // pending check starts the sequence at full close
        if (state_next.pending && pos_zero) begin
          ph = item.reed_closed ? PH_IDLE : PH_OPEN;
          state_next.pending = 1'b0;
          tick_count = 8'd0;
        end
        tick_count = tick_count + 8'd1;
        state_next.phase = ph;
        if (tick_count < cfg.jam_phase_ticks) begin
          state_next.timer = tick_count;
        end else begin
          state_next.timer = 8'd0;
          case (ph)
            PH_IDLE: begin
            end
            PH_OPEN: begin
              if (state.retry < cfg.jam_retry_max) state_next.retry = state.retry + 8'd1;
              open_req_next = 1'b1;
              cmd.drive = DRV_OPEN;
              if (at_full && item.outer_door_full) state_next.phase = PH_FEEDER_BACK;
            end
            PH_FEEDER_BACK: begin
              open_req_next = 1'b1;
              cmd.drive = DRV_OPEN;
              state_next.feeder_busy = 1'b1;
              cmd.feed = 1'b1;
              state_next.phase = PH_FEEDER_WAIT;
            end
            PH_FEEDER_WAIT: begin
              open_req_next = 1'b1;
              cmd.drive = DRV_OPEN;
              if (!state_next.feeder_busy) state_next.phase = PH_CLOSE;
            end
            PH_CLOSE: begin
              open_req_next = 1'b0;
              cmd.drive = DRV_OPEN;
              state_next.phase = PH_CLOSE_CHECK;
            end
            PH_CLOSE_CHECK: begin
              retry_spent = (state.retry >= cfg.jam_retry_max);
              if (pos_zero) begin
                if (item.reed_closed) state_next.phase = PH_DONE;
                else state_next.phase = retry_spent ? PH_ERROR : PH_OPEN;
              end
            end
            PH_DONE: begin
              state_next.phase = PH_IDLE;
              cmd.drive = DRV_CLOSE;
            end
            PH_ERROR: begin
              state_next.phase = PH_VOICE;
              cmd.drive = DRV_CLOSE;
            end
            PH_VOICE: begin
              if (item.outer_door_shut) begin
                state_next.phase = PH_IDLE;
                if (state.voice_count < cfg.voice_alert_max) begin
                  cmd.voice = 1'b1;
                  state_next.voice_count = state.voice_count + 8'd1;
                end
              end
            end
            default: state_next.phase = PH_IDLE;
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/inner_door_stepper_jam_recovery_unit.sv
// Inner ice door stepper with jam recovery. Each tick item (one 3 ms tick) is
// caught in an input register, evaluated combinationally by the door stepping
// logic and the jam sequencer, and its result lands in an output register;
// the block takes one item per clock cycle while the result is not stalled,
// with the input register parting the two sides so a stalled result does not
// lose the item behind it. Configuration writes are always ready and take
// effect for the next item; indexes beyond the register list are ignored.
// door_position is POSITION_BITS wide.
`default_nettype none
module inner_door_stepper_jam_recovery_unit #(
  parameter int POSITION_BITS = idsj_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  idsj_tick_if.sink   tick,
  idsj_cfg_if.sink    cfg,
  idsj_result_if.source result
);
  import idsj_pkg::*;

  cfg_t                     regs;
  logic                     in_valid;
  tick_t                    in_item;
  logic                     out_valid;
  logic                     fire;

  logic [POSITION_BITS-1:0] position, position_next;
  door_flags_t              flags, flags_next;
  logic [9:0]               pause_count, pause_next;
  logic [3:0]               coil_reg, coil_next;
  jam_state_t               jam, jam_next;
  logic                     run_jam, open_req_final;
  jam_cmd_t                 cmd;

  tick_t                    tick_item;

  assign tick_item = '{
    open_set: tick.open_set, open_clear: tick.open_clear,
    force_close_set: tick.force_close_set,
    front_above_threshold: tick.front_above_threshold,
    close_hold: tick.close_hold, extracting: tick.extracting,
    reed_closed: tick.reed_closed, jam_enable: tick.jam_enable,
    outer_door_full: tick.outer_door_full, outer_door_shut: tick.outer_door_shut,
    feeder_reverse_done: tick.feeder_reverse_done, jam_check_set: tick.jam_check_set
  };

  assign fire       = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || fire;
  assign cfg.ready  = 1'b1;

  idsj_door #(.POSITION_BITS(POSITION_BITS)) u_door (
    .item          (in_item),
    .cfg           (regs),
    .position      (position),
    .flags         (flags),
    .pause_count   (pause_count),
    .coil_reg      (coil_reg),
    .phase         (jam.phase),
    .position_next (position_next),
    .flags_next    (flags_next),
    .pause_next    (pause_next),
    .coil_next     (coil_next),
    .run_jam       (run_jam)
  );

  idsj_jam #(.POSITION_BITS(POSITION_BITS)) u_jam (
    .item          (in_item),
    .cfg           (regs),
    .position      (position_next),
    .run_jam       (run_jam),
    .open_req      (flags_next.open_req),
    .state         (jam),
    .state_next    (jam_next),
    .open_req_next (open_req_final),
    .cmd           (cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{full_open_steps: FULL_OPEN_STEPS_RST,
                first_stage_steps: FIRST_STAGE_STEPS_RST,
                stage_pause_ticks: STAGE_PAUSE_TICKS_RST,
                jam_phase_ticks: JAM_PHASE_TICKS_RST,
                jam_retry_max: JAM_RETRY_MAX_RST,
                voice_alert_max: VOICE_ALERT_MAX_RST};
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FULL_OPEN_STEPS:   regs.full_open_steps   <= cfg.data[11:0];
        CFG_FIRST_STAGE_STEPS: regs.first_stage_steps <= cfg.data[11:0];
        CFG_STAGE_PAUSE_TICKS: regs.stage_pause_ticks <= cfg.data[9:0];
        CFG_JAM_PHASE_TICKS:   regs.jam_phase_ticks   <= cfg.data[7:0];
        CFG_JAM_RETRY_MAX:     regs.jam_retry_max     <= cfg.data[7:0];
        CFG_VOICE_ALERT_MAX:   regs.voice_alert_max   <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // handshake and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      position    <= '0;
      flags       <= '0;
      pause_count <= '0;
      coil_reg    <= '0;
      jam         <= '{pending: 1'b0, phase: PH_IDLE, timer: 8'd0, retry: 8'd0,
                       voice_count: 8'd0, feeder_busy: 1'b0};
    end else begin
      if (tick.valid && tick.ready) in_valid <= 1'b1;
      else if (fire) in_valid <= 1'b0;
      if (fire) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      if (fire) begin
        position    <= position_next;
        flags       <= '{opening: flags_next.opening, open_req: open_req_final,
                         force_close: flags_next.force_close};
        pause_count <= pause_next;
        coil_reg    <= coil_next;
        jam         <= jam_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) in_item <= tick_item;
    if (fire) begin
      result.coil_phases          <= coil_next;
      result.door_position        <= position_next;
      result.open_request         <= open_req_final;
      result.outer_door_drive     <= cmd.drive;
      result.feeder_reverse_start <= cmd.feed;
      result.voice_alert          <= cmd.voice;
      result.jam_phase            <= jam_next.phase;
    end
  end

  assign result.valid = out_valid;

`include "inner_door_stepper_jam_recovery_unit_assert.svh"

  `IDSJ_ASSERT_NOW(a_no_overwrite, out_valid && !result.ready, !fire, "result overwritten while stalled")
  `IDSJ_ASSERT_NOW(a_in_free_ready, !in_valid, tick.ready, "empty input register not ready")
  `IDSJ_ASSERT_NOW(a_feed_phase, out_valid && result.feeder_reverse_start, result.jam_phase == PH_FEEDER_WAIT, "feeder start outside feeder wait")
  `IDSJ_ASSERT_NOW(a_voice_phase, out_valid && result.voice_alert, result.jam_phase == PH_IDLE && result.outer_door_drive == DRV_NONE, "voice alert outside return to idle")
  `IDSJ_ASSERT_NEXT(a_fire_shows, fire, out_valid, "evaluated item not presented")

endmodule
`default_nettype wire
